>>> rtl/core/dkc_pkg.sv
package dkc_pkg;

   // configuration register indexes
   localparam int unsigned CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_Y_WINDOW     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_X_WINDOW     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NU_WINDOW    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_Q2_WINDOW    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_W2_WINDOW    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_BOUND_ENABLE = 3'd5;

   // bound enable pairs, min bit then max bit
   localparam int unsigned EN_Y  = 0;
   localparam int unsigned EN_X  = 2;
   localparam int unsigned EN_NU = 4;
   localparam int unsigned EN_Q2 = 6;
   localparam int unsigned EN_W2 = 8;
   localparam int unsigned EN_W  = 10;

   // square root and quotient geometry
   localparam int unsigned RAD_W    = 64;
   localparam int unsigned ROOT_W   = 32;
   localparam int unsigned QUO_W    = 32;
   localparam int unsigned SQRT_LAT = ROOT_W;
   localparam int unsigned DIV_LAT  = QUO_W + 2;

endpackage

>>> rtl/core/dkc_sqrt_pipe.sv
// Floor square root, one root bit per stage, two radicand bits consumed per stage.
module dkc_sqrt_pipe (
   input  logic                          clock,
   input  logic                          en,
   input  logic [dkc_pkg::RAD_W-1:0]     radicand,
   output logic [dkc_pkg::ROOT_W-1:0]    root
);

   localparam int unsigned RW  = dkc_pkg::ROOT_W;
   localparam int unsigned DW  = dkc_pkg::RAD_W;
   localparam int unsigned REM_W = RW + 1;

   logic [REM_W-1:0] rem_ff  [RW];
   logic [REM_W-1:0] rem_in  [RW];
   logic [RW-1:0]    root_ff [RW];
   logic [RW-1:0]    root_in [RW];
   logic [DW-1:0]    opd_ff  [RW];
   logic [DW-1:0]    opd_in  [RW];

   logic [REM_W-1:0] cur_rem  [RW];
   logic [RW-1:0]    cur_root [RW];
   logic [DW-1:0]    cur_opd  [RW];
   logic [REM_W+1:0] shifted  [RW];
   logic [REM_W+2:0] diff     [RW];
   logic             ge       [RW];

   // per-stage trial subtract
   always_comb begin
      for (int k = 0; k < RW; k++) begin
         if (k == 0) begin
            cur_rem[k]  = '0;
            cur_root[k] = '0;
            cur_opd[k]  = radicand;
         end else begin
            cur_rem[k]  = rem_ff[k-1];
            cur_root[k] = root_ff[k-1];
            cur_opd[k]  = opd_ff[k-1];
         end
         shifted[k] = {cur_rem[k], cur_opd[k][DW-1 -: 2]};
         diff[k]    = {1'b0, shifted[k]} - {2'b00, cur_root[k], 2'b01};
         ge[k]      = ~diff[k][REM_W+2];
         rem_in[k]  = ge[k] ? diff[k][REM_W-1:0] : shifted[k][REM_W-1:0];
         root_in[k] = {cur_root[k][RW-2:0], ge[k]};
         opd_in[k]  = {cur_opd[k][DW-3:0], 2'b00};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < RW; k++) begin
            rem_ff[k]  <= rem_in[k];
            root_ff[k] <= root_in[k];
            opd_ff[k]  <= opd_in[k];
         end
      end
   end

   assign root = root_ff[RW-1];

endmodule

>>> rtl/core/dkc_div_pipe.sv
// Unsigned restoring divide, one quotient bit per stage, signed saturated result.
// Overflow of the quotient field is found up front and forces saturation.
module dkc_div_pipe #(
   parameter int unsigned NUM_W = 96,
   parameter int unsigned DEN_W = 68
) (
   input  logic                        clock,
   input  logic                        en,
   input  logic [NUM_W-1:0]            num_abs,
   input  logic [DEN_W-1:0]            den_abs,
   input  logic                        neg,
   output logic [dkc_pkg::QUO_W-1:0]   quo
);

   localparam int unsigned QW    = dkc_pkg::QUO_W;
   localparam int unsigned HI_W  = NUM_W - QW;
   localparam int unsigned CMP_W = (HI_W > DEN_W) ? HI_W : DEN_W;
   localparam logic [QW-1:0] MIN_MAG = {1'b1, {(QW-1){1'b0}}};

   // entry stage: overflow check and initial remainder
   logic [CMP_W-1:0] hi_ext;
   logic [CMP_W-1:0] den_ext;
   logic             a_ovf_ff;
   logic [DEN_W-1:0] a_rem_ff;
   logic [QW-1:0]    a_lo_ff;
   logic [DEN_W-1:0] a_den_ff;
   logic             a_neg_ff;

   assign hi_ext  = CMP_W'(num_abs[NUM_W-1:QW]);
   assign den_ext = CMP_W'(den_abs);

   always_ff @(posedge clock) begin
      if (en) begin
         a_ovf_ff <= (hi_ext >= den_ext);
         a_rem_ff <= DEN_W'(num_abs[NUM_W-1:QW]);
         a_lo_ff  <= num_abs[QW-1:0];
         a_den_ff <= den_abs;
         a_neg_ff <= neg;
      end
   end

   // quotient bit stages
   logic [DEN_W-1:0] rem_ff [QW];
   logic [DEN_W-1:0] rem_in [QW];
   logic [QW-1:0]    lo_ff  [QW];
   logic [QW-1:0]    lo_in  [QW];
   logic [QW-1:0]    quo_ff [QW];
   logic [QW-1:0]    quo_in [QW];
   logic [DEN_W-1:0] den_ff [QW];
   logic             neg_ff [QW];
   logic             ovf_ff [QW];

   logic [DEN_W-1:0] cur_rem [QW];
   logic [QW-1:0]    cur_lo  [QW];
   logic [QW-1:0]    cur_quo [QW];
   logic [DEN_W-1:0] cur_den [QW];
   logic             cur_neg [QW];
   logic             cur_ovf [QW];
   logic [DEN_W:0]   trial   [QW];
   logic [DEN_W+1:0] diff    [QW];
   logic             ge      [QW];

   always_comb begin
      for (int k = 0; k < QW; k++) begin
         if (k == 0) begin
            cur_rem[k] = a_rem_ff;
            cur_lo[k]  = a_lo_ff;
            cur_quo[k] = '0;
            cur_den[k] = a_den_ff;
            cur_neg[k] = a_neg_ff;
            cur_ovf[k] = a_ovf_ff;
         end else begin
            cur_rem[k] = rem_ff[k-1];
            cur_lo[k]  = lo_ff[k-1];
            cur_quo[k] = quo_ff[k-1];
            cur_den[k] = den_ff[k-1];
            cur_neg[k] = neg_ff[k-1];
            cur_ovf[k] = ovf_ff[k-1];
         end
         trial[k]  = {cur_rem[k], cur_lo[k][QW-1]};
         diff[k]   = {1'b0, trial[k]} - {2'b00, cur_den[k]};
         ge[k]     = ~diff[k][DEN_W+1];
         rem_in[k] = ge[k] ? diff[k][DEN_W-1:0] : trial[k][DEN_W-1:0];
         quo_in[k] = {cur_quo[k][QW-2:0], ge[k]};
         lo_in[k]  = {cur_lo[k][QW-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < QW; k++) begin
            rem_ff[k] <= rem_in[k];
            lo_ff[k]  <= lo_in[k];
            quo_ff[k] <= quo_in[k];
            den_ff[k] <= cur_den[k];
            neg_ff[k] <= cur_neg[k];
            ovf_ff[k] <= cur_ovf[k];
         end
      end
   end

   // sign and saturation
   logic [QW-1:0] mag;
   logic [QW-1:0] quo_sat_ff;

   assign mag = quo_ff[QW-1];

   always_ff @(posedge clock) begin
      if (en) begin
         if (neg_ff[QW-1]) begin
            quo_sat_ff <= (ovf_ff[QW-1] || (mag > MIN_MAG)) ? MIN_MAG : (~mag + 1'b1);
         end else begin
            quo_sat_ff <= (ovf_ff[QW-1] || mag[QW-1]) ? ~MIN_MAG : mag;
         end
      end
   end

   assign quo = quo_sat_ff;

endmodule

>>> rtl/core/dis_event_kinematic_cut.sv
// Deep-inelastic event kinematics and window cut. Each item carries the target, beam and
// scattered-lepton four-momenta in signed Q16.16 GeV; the result gives nu, Q2, W2, Bjorken x
// and y (saturated) plus accepted and degenerate flags. One item enters per clock and one
// result leaves per clock. There are four stages for the 33x33 products, dot products and
// derived terms, a 32-stage bit-per-cycle square root followed by a 34-stage bit-per-cycle
// divider on the nu path (x and y dividers run alongside), and one stage for the window
// compares. When the result side stalls the whole pipeline holds. The user must write window
// registers through the csr port only while no item is in flight; the block does not check.
module dis_event_kinematic_cut (
   input  logic                              clock,
   input  logic                              reset,
   // stream in
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // target E,px,py,pz; beam E,px,py,pz; scattered E,px,py,pz; 32 bits each from bit 0
   input  logic [383:0]                      req_tdata,
   // stream out
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // energy_transfer[31:0], virtuality[79:32], hadronic_mass_sq[127:80],
   // scaling_x[159:128], inelasticity[191:160]
   output logic [191:0]                      rsp_tdata,
   // accepted[0], degenerate[1]
   output logic [1:0]                        rsp_tuser,
   // register writes
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [dkc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [63:0]                       csr_data
);

   localparam int unsigned XY_DLY   = dkc_pkg::SQRT_LAT;
   localparam int unsigned META_DLY = dkc_pkg::SQRT_LAT + dkc_pkg::DIV_LAT;
   localparam int unsigned VLD_LEN  = 4 + META_DLY;

   typedef struct packed {
      logic        pp_pos;
      logic        pq_nz;
      logic        pk_nz;
      logic [47:0] q2o;
      logic [47:0] w2o;
   } meta_type;

   typedef struct packed {
      logic        neg;
      logic [66:0] num;
   } nu_arg_type;

   typedef struct packed {
      logic [31:0] x;
      logic [31:0] y;
   } xy_type;

   // configuration registers
   logic [63:0] y_window_ff, x_window_ff, nu_window_ff, q2_window_ff, w2_window_ff;
   logic [dkc_pkg::EN_W-1:0] bound_enable_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         y_window_ff     <= '0;
         x_window_ff     <= '0;
         nu_window_ff    <= '0;
         q2_window_ff    <= '0;
         w2_window_ff    <= '0;
         bound_enable_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            dkc_pkg::CSR_Y_WINDOW:     y_window_ff  <= csr_data;
            dkc_pkg::CSR_X_WINDOW:     x_window_ff  <= csr_data;
            dkc_pkg::CSR_NU_WINDOW:    nu_window_ff <= csr_data;
            dkc_pkg::CSR_Q2_WINDOW:    q2_window_ff <= csr_data;
            dkc_pkg::CSR_W2_WINDOW:    w2_window_ff <= csr_data;
            dkc_pkg::CSR_BOUND_ENABLE: bound_enable_ff <= csr_data[dkc_pkg::EN_W-1:0];
            default: ;
         endcase
      end
   end

   // pipeline advance: the whole pipe moves when the output slot is free or being taken
   logic adv;
   logic rsp_valid_ff;
   logic [VLD_LEN-1:0] vld_ff;

   assign adv        = !rsp_valid_ff || rsp_tready;
   assign req_tready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         vld_ff       <= {vld_ff[VLD_LEN-2:0], req_tvalid};
         rsp_valid_ff <= vld_ff[VLD_LEN-1];
      end
   end

   // stage 1: capture vectors, form q = k - k'
   logic signed [31:0] p_ff [4];
   logic signed [31:0] k_ff [4];
   logic signed [32:0] q_ff [4];

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 4; i++) begin
            p_ff[i] <= $signed(req_tdata[32*i +: 32]);
            k_ff[i] <= $signed(req_tdata[32*(4+i) +: 32]);
            q_ff[i] <= 33'($signed(req_tdata[32*(4+i) +: 32]))
                     - 33'($signed(req_tdata[32*(8+i) +: 32]));
         end
      end
   end

   // stage 2: component products
   logic signed [63:0] mpp_ff [4];
   logic signed [64:0] mpq_ff [4];
   logic signed [63:0] mpk_ff [4];
   logic signed [65:0] mqq_ff [4];

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 4; i++) begin
            mpp_ff[i] <= p_ff[i] * p_ff[i];
            mpq_ff[i] <= p_ff[i] * q_ff[i];
            mpk_ff[i] <= p_ff[i] * k_ff[i];
            mqq_ff[i] <= q_ff[i] * q_ff[i];
         end
      end
   end

   // stage 3: Minkowski products
   logic signed [67:0] pp_ff, pq_ff, pk_ff, qq_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         pp_ff <= 68'(mpp_ff[0]) - 68'(mpp_ff[1]) - 68'(mpp_ff[2]) - 68'(mpp_ff[3]);
         pq_ff <= 68'(mpq_ff[0]) - 68'(mpq_ff[1]) - 68'(mpq_ff[2]) - 68'(mpq_ff[3]);
         pk_ff <= 68'(mpk_ff[0]) - 68'(mpk_ff[1]) - 68'(mpk_ff[2]) - 68'(mpk_ff[3]);
         qq_ff <= 68'(mqq_ff[0]) - 68'(mqq_ff[1]) - 68'(mqq_ff[2]) - 68'(mqq_ff[3]);
      end
   end

   // stage 4: Q2, W2, flags, divider operands
   function automatic logic [47:0] sat48(input logic signed [53:0] v);
      logic [47:0] r;
      if ((v[53:47] == 7'h00) || (v[53:47] == 7'h7f)) begin
         r = v[47:0];
      end else begin
         r = v[53] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
      end
      return r;
   endfunction

   logic signed [67:0] q2_full;
   logic signed [69:0] w2_full;
   logic signed [67:0] q2_shr;
   logic signed [69:0] w2_shr;
   logic [67:0]        q2_abs, pq_abs, pk_abs;
   logic               pp_pos;
   meta_type           meta_in;

   assign q2_full = -qq_ff;
   assign w2_full = 70'(pp_ff) + (70'(pq_ff) <<< 1) + 70'(qq_ff);
   assign q2_shr  = q2_full >>> 16;
   assign w2_shr  = w2_full >>> 16;
   assign q2_abs  = q2_full[67] ? 68'(-q2_full) : 68'(q2_full);
   assign pq_abs  = pq_ff[67] ? 68'(-pq_ff) : 68'(pq_ff);
   assign pk_abs  = pk_ff[67] ? 68'(-pk_ff) : 68'(pk_ff);
   assign pp_pos  = !pp_ff[67] && (pp_ff != '0);

   always_comb begin
      meta_in.pp_pos = pp_pos;
      meta_in.pq_nz  = (pq_ff != '0);
      meta_in.pk_nz  = (pk_ff != '0);
      meta_in.q2o    = sat48(54'(q2_shr));
      meta_in.w2o    = sat48(54'(w2_shr));
   end

   meta_type    meta_ff;
   logic [63:0] sqrt_in_ff;
   nu_arg_type  nu_arg_ff;
   logic [94:0] x_num_ff, y_num_ff;
   logic [67:0] x_den_ff;
   logic [65:0] y_den_ff;
   logic        x_neg_ff, y_neg_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         meta_ff       <= meta_in;
         sqrt_in_ff    <= pp_pos ? pp_ff[63:0] : 64'd0;
         nu_arg_ff.neg <= pq_ff[67];
         nu_arg_ff.num <= pq_abs[66:0];
         x_num_ff      <= {q2_abs[66:0], 28'd0};
         x_den_ff      <= {pq_abs[66:0], 1'b0};
         x_neg_ff      <= q2_full[67] ^ pq_ff[67];
         y_num_ff      <= {pq_abs[66:0], 28'd0};
         y_den_ff      <= pk_abs[65:0];
         y_neg_ff      <= pq_ff[67] ^ pk_ff[67];
      end
   end

   // nu path: square root of P.P, then P.q over it
   logic [dkc_pkg::ROOT_W-1:0] root;
   nu_arg_type nu_dly_ff [XY_DLY];
   logic [31:0] nu_quo, x_quo, y_quo;

   dkc_sqrt_pipe u_sqrt (
      .clock    (clock),
      .en       (adv),
      .radicand (sqrt_in_ff),
      .root     (root)
   );

   dkc_div_pipe #(.NUM_W(67), .DEN_W(32)) u_div_nu (
      .clock   (clock),
      .en      (adv),
      .num_abs (nu_dly_ff[XY_DLY-1].num),
      .den_abs (root),
      .neg     (nu_dly_ff[XY_DLY-1].neg),
      .quo     (nu_quo)
   );

   dkc_div_pipe #(.NUM_W(95), .DEN_W(68)) u_div_x (
      .clock   (clock),
      .en      (adv),
      .num_abs (x_num_ff),
      .den_abs (x_den_ff),
      .neg     (x_neg_ff),
      .quo     (x_quo)
   );

   dkc_div_pipe #(.NUM_W(95), .DEN_W(66)) u_div_y (
      .clock   (clock),
      .en      (adv),
      .num_abs (y_num_ff),
      .den_abs (y_den_ff),
      .neg     (y_neg_ff),
      .quo     (y_quo)
   );

   // alignment delays
   xy_type   xy_dly_ff   [XY_DLY];
   meta_type meta_dly_ff [META_DLY];

   always_ff @(posedge clock) begin
      if (adv) begin
         nu_dly_ff[0]   <= nu_arg_ff;
         xy_dly_ff[0]   <= '{x: x_quo, y: y_quo};
         for (int i = 1; i < XY_DLY; i++) begin
            nu_dly_ff[i] <= nu_dly_ff[i-1];
            xy_dly_ff[i] <= xy_dly_ff[i-1];
         end
         meta_dly_ff[0] <= meta_ff;
         for (int i = 1; i < META_DLY; i++) begin
            meta_dly_ff[i] <= meta_dly_ff[i-1];
         end
      end
   end

   // final stage: zero forcing, windows, output register
   function automatic logic win_ok(input logic signed [48:0] v,
                                   input logic signed [48:0] mn,
                                   input logic signed [48:0] mx,
                                   input logic [1:0]         en);
      return (!en[0] || (mn < v)) && (!en[1] || (v < mx));
   endfunction

   meta_type    m_end;
   logic [31:0] nu_v, x_v, y_v;
   logic        degen, ok;

   assign m_end = meta_dly_ff[META_DLY-1];
   assign nu_v  = m_end.pp_pos ? nu_quo : 32'd0;
   assign x_v   = m_end.pq_nz ? xy_dly_ff[XY_DLY-1].x : 32'd0;
   assign y_v   = m_end.pk_nz ? xy_dly_ff[XY_DLY-1].y : 32'd0;
   assign degen = !m_end.pp_pos || !m_end.pq_nz || !m_end.pk_nz;

   always_comb begin
      ok = !degen
         && win_ok(49'($signed(y_v)), 49'($signed(y_window_ff[31:0])),
                   49'($signed(y_window_ff[63:32])), bound_enable_ff[dkc_pkg::EN_Y +: 2])
         && win_ok(49'($signed(x_v)), 49'($signed(x_window_ff[31:0])),
                   49'($signed(x_window_ff[63:32])), bound_enable_ff[dkc_pkg::EN_X +: 2])
         && win_ok(49'($signed(nu_v)), 49'($signed(nu_window_ff[31:0])),
                   49'($signed(nu_window_ff[63:32])), bound_enable_ff[dkc_pkg::EN_NU +: 2])
         && win_ok(49'($signed(m_end.q2o)), $signed({9'd0, q2_window_ff[31:0], 8'd0}),
                   $signed({9'd0, q2_window_ff[63:32], 8'd0}),
                   bound_enable_ff[dkc_pkg::EN_Q2 +: 2])
         && win_ok(49'($signed(m_end.w2o)), $signed({9'd0, w2_window_ff[31:0], 8'd0}),
                   $signed({9'd0, w2_window_ff[63:32], 8'd0}),
                   bound_enable_ff[dkc_pkg::EN_W2 +: 2]);
   end

   logic [191:0] rsp_data_ff;
   logic [1:0]   rsp_user_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_data_ff <= {y_v, x_v, m_end.w2o, m_end.q2o, nu_v};
         rsp_user_ff <= {degen, ok};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule
